/* design/lraq_pkg.sv */
package lraq_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_LIMIT = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    logic    deq_ok;
    logic    empty;
    logic    full;
    logic    exhausted;
  } step_res_t;

endpackage

/* design/lraq_in_if.sv */
interface lraq_in_if;
  logic                               valid;
  logic                               ready;
  logic [0:0]                         operation;
  logic signed [lraq_pkg::DATA_W-1:0] data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink   (input valid, input operation, input data_in, output ready);
endinterface

/* design/lraq_out_if.sv */
interface lraq_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [lraq_pkg::DATA_W-1:0] data_out;
  logic                               empty_flag;
  logic                               full_flag;
  logic                               exhausted_flag;

  modport source (output valid, output status, output data_out, output empty_flag,
                  output full_flag, output exhausted_flag, input ready);
  modport sink   (input valid, input status, input data_out, input empty_flag,
                  input full_flag, input exhausted_flag, output ready);
endinterface

/* design/linear_array_queue_unit.sv */
// Linear FIFO of signed 32-bit values, slots used once each.
// in_ch transfers an operation (enqueue or dequeue) with a data word;
// out_ch transfers one result per operation: status, dequeued data and
// the empty, full and exhausted flags as they stand after the operation.
// cfg_we/cfg_wdata write the capacity; write it only while no operation
// is in flight.
// The decision and the slot memory read are registered in the first stage,
// the output register is the second. Throughput: one operation per cycle
// while out_ch does not stall, set by the single-port write / single-port
// read slot memory and the one-step counter update.
// Reset clears the counts, the exhausted state and both pipeline stages
// and sets the capacity to 64; slot contents are not cleared.
// When out_ch stalls, the output register holds its result, a second
// operation waits in the stage behind it, and in_ch.ready drops once
// both are occupied.
module linear_array_queue_unit #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lraq_pkg::CAP_W-1:0]  cfg_wdata,
  lraq_in_if.sink                     in_ch,
  lraq_out_if.source                  out_ch
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lraq_pkg::step_res_t                res;
  lraq_pkg::step_res_t                s1_res_r;
  logic                               s1_v_r;
  logic                               out_v_r;
  lraq_pkg::step_res_t                out_res_r;
  logic signed [lraq_pkg::DATA_W-1:0] out_data_r;
  logic signed [lraq_pkg::DATA_W-1:0] rd_data;
  logic                               wr_en, rd_en;
  logic [ADDR_W-1:0]                  wr_addr, rd_addr;
  logic                               acc, s2_load, in_rdy;

  assign s2_load = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_rdy  = !s1_v_r || s2_load;
  assign acc     = in_ch.valid && in_rdy;

  lraq_ctrl #(
    .DEPTH  (DEPTH),
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .op        (in_ch.operation),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  lraq_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.data_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (s2_load) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_res_r  <= s1_res_r;
      out_data_r <= s1_res_r.deq_ok ? rd_data : '0;
    end
  end

  assign in_ch.ready           = in_rdy;
  assign out_ch.valid          = out_v_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.data_out       = out_data_r;
  assign out_ch.empty_flag     = out_res_r.empty;
  assign out_ch.full_flag      = out_res_r.full;
  assign out_ch.exhausted_flag = out_res_r.exhausted;

endmodule

/* design/lraq_mem.sv */
module lraq_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [ADDR_W-1:0]                  wr_addr,
  input  logic signed [lraq_pkg::DATA_W-1:0] wr_data,
  input  logic                               rd_en,
  input  logic [ADDR_W-1:0]                  rd_addr,
  output logic signed [lraq_pkg::DATA_W-1:0] rd_data
);

  logic signed [lraq_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [lraq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/lraq_ctrl.sv */
module lraq_ctrl #(
  parameter int DEPTH  = 64,
  parameter int CNT_W  = 7,
  parameter int ADDR_W = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lraq_pkg::CAP_W-1:0]      cfg_wdata,
  input  logic                            acc,
  input  logic [0:0]                      op,
  output lraq_pkg::step_res_t             res,
  output logic                            wr_en,
  output logic [ADDR_W-1:0]               wr_addr,
  output logic                            rd_en,
  output logic [ADDR_W-1:0]               rd_addr
);

  localparam int CMP_W = (CNT_W > lraq_pkg::CAP_W) ? CNT_W : lraq_pkg::CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
  localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

  logic [lraq_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]           wc_r, wc_nxt;
  logic [CNT_W-1:0]           rc_r, rc_nxt;
  logic                       exh_r, exh_nxt;
  logic [CMP_W-1:0]           cap_ext;
  logic [CMP_W-1:0]           eff_cap;
  logic [CMP_W-1:0]           wc_ext, rc_ext, rc_inc_ext, wc_nxt_ext, rc_nxt_ext;
  logic                       enq_go, deq_go;

  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = ONE_C;
    end else if (cap_ext > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    wc_ext     = CMP_W'(wc_r);
    rc_ext     = CMP_W'(rc_r);
    rc_inc_ext = rc_ext + ONE_C;
    enq_go     = 1'b0;
    deq_go     = 1'b0;
    wc_nxt     = wc_r;
    rc_nxt     = rc_r;
    exh_nxt    = exh_r;
    res.status = lraq_pkg::ST_DONE;
    if (op == lraq_pkg::OP_ENQ) begin
      if (exh_r) begin
        res.status = lraq_pkg::ST_LIMIT;
      end else if (wc_ext >= eff_cap) begin
        res.status = lraq_pkg::ST_FULL;
      end else begin
        enq_go = 1'b1;
        wc_nxt = wc_r + CNT_W'(1);
      end
    end else begin
      if (exh_r || (rc_ext >= wc_ext) || (rc_ext >= DEPTH_C)) begin
        res.status = lraq_pkg::ST_EMPTY;
      end else begin
        deq_go = 1'b1;
        rc_nxt = rc_r + CNT_W'(1);
        if (rc_inc_ext >= eff_cap) begin
          exh_nxt = 1'b1;
        end
      end
    end
    wc_nxt_ext    = CMP_W'(wc_nxt);
    rc_nxt_ext    = CMP_W'(rc_nxt);
    res.deq_ok    = deq_go;
    res.exhausted = exh_nxt;
    res.empty     = exh_nxt || (rc_nxt_ext >= wc_nxt_ext);
    res.full      = !exh_nxt && (wc_nxt_ext >= eff_cap);
  end

  assign wr_en   = acc && enq_go;
  assign wr_addr = wc_r[ADDR_W-1:0];
  assign rd_en   = acc && deq_go;
  assign rd_addr = rc_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lraq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r  <= '0;
      rc_r  <= '0;
      exh_r <= 1'b0;
    end else if (acc) begin
      wc_r  <= wc_nxt;
      rc_r  <= rc_nxt;
      exh_r <= exh_nxt;
    end
  end

endmodule

/* design/lraq_check.sv */
module lraq_check (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         out_status,
  input logic signed [lraq_pkg::DATA_W-1:0] out_data,
  input logic                               out_empty,
  input logic                               out_full,
  input logic                               out_exhausted
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data) && $stable(out_status))
    else $error("result changed while stalled");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lraq_pkg::ST_DONE) |-> out_data == '0)
    else $error("data on a rejected operation");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exhausted |-> out_empty && !out_full)
    else $error("exhausted queue reports readable or full");

endmodule

bind linear_array_queue_unit lraq_check u_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_data      (out_ch.data_out),
  .out_empty     (out_ch.empty_flag),
  .out_full      (out_ch.full_flag),
  .out_exhausted (out_ch.exhausted_flag)
);
